// File: design/trcw_pkg.sv
`timescale 1ns / 1ps

package trcw_pkg;

    // Event codes carried in the opcode field
    localparam logic [1:0] OP_NEW_ACK = 2'd0;
    localparam logic [1:0] OP_DUP_ACK = 2'd1;
    localparam logic [1:0] OP_START   = 2'd2;

    // Configuration register indexes
    localparam logic CFG_MSS     = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    localparam logic [15:0] RESET_MSS       = 16'd1460;
    localparam logic [15:0] RESET_TIMEOUT   = 16'd3000;
    localparam logic [31:0] START_THRESHOLD = 32'd65535;
    localparam logic [16:0] RTO_CAP         = 17'd64000;
    localparam logic [3:0]  DUP_LIMIT       = 4'd3;
    localparam logic [3:0]  DUP_SAT         = 4'd15;

    localparam int          DIV_W     = 32;
    localparam logic [5:0]  DIV_STEPS = 6'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

    // 32-bit add that sticks at all ones on overflow
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// File: design/trcw_divider.sv
`timescale 1ns / 1ps

module trcw_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [trcw_pkg::DIV_W-1:0] i_dividend,
    input  logic [trcw_pkg::DIV_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [trcw_pkg::DIV_W-1:0] o_quotient
);
    import trcw_pkg::*;

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_divisor;
    logic [5:0]       r_cnt;
    logic             r_done;

    logic [DIV_W:0]   shifted;
    logic [DIV_W:0]   diff;
    logic             ge;

    // one restoring step: shift in next dividend bit, trial subtract
    always_comb begin
        shifted = {r_rem, r_quo[DIV_W-1]};
        ge      = shifted >= {1'b0, r_divisor};
        diff    = shifted - {1'b0, r_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= DIV_STEPS;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 6'd1;
                r_done <= (r_cnt == 6'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: design/tcp_reno_congestion_window.sv
`timescale 1ns / 1ps

// TCP Reno congestion window engine for one connection. Each input item is
// one event (new ACK, duplicate ACK, connection start) and yields exactly one
// result item holding the window, threshold, recovery flag, retransmit
// request/length and the current timeout. An event passes from acceptance
// through the execute and done states to the result register, except a new
// ACK in congestion avoidance, which squares mss in one registered multiply
// and divides by the window in a radix-2 restoring divider of 32 steps
// before the done state. The input is not ready while an event is in flight;
// a finished result sits in its own register, so the next event can be taken
// while the result still waits for the sink. The configuration port is always
// ready, and new values are used by every later step, also of an event in flight.
module tcp_reno_congestion_window (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [1:0] opcode, [33:2] bytes_in_flight, rest zero
    // result items
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,   // [31:0] congestion_window, [63:32] slow_start_threshold,
                                     // [79:64] retransmit_length, [95:80] timeout_value
    output logic [1:0]  o_m_tuser,   // [0] in_recovery, [1] retransmit_request
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import trcw_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic [15:0] r_mss;
    logic [15:0] r_init_timeout;

    // connection state
    logic [31:0] r_window;
    logic [31:0] r_threshold;
    logic [3:0]  r_dup_cnt;
    logic        r_recovery;
    logic [15:0] r_timeout;

    // latched event
    logic [1:0]  r_op;
    logic [31:0] r_unacked;
    logic        r_rexmit;
    logic [15:0] r_rexmit_len;
    logic [31:0] r_prod;

    // result register
    logic        r_out_valid;
    logic [95:0] r_out_data;
    logic [1:0]  r_out_user;

    // control from the sequencer
    logic s_ready, exec_en, mul_en, div_start, out_load;

    logic        div_done;
    logic [31:0] div_quo;

    // event decode
    logic        in_accept;
    logic [3:0]  dup_inc;
    logic        fast_rexmit;
    logic        use_div;
    logic [16:0] mss_x2;
    logic [17:0] mss_x3;
    logic [31:0] half_win;
    logic [31:0] new_thr;
    logic [16:0] rto_x2;
    logic [15:0] rto_next;

    assign in_accept = i_s_tvalid && o_s_tready;

    always_comb begin
        dup_inc     = (r_dup_cnt < DUP_SAT) ? r_dup_cnt + 4'd1 : r_dup_cnt;
        fast_rexmit = (dup_inc == DUP_LIMIT) && !r_recovery;
        // congestion avoidance needs mss*mss / window
        use_div     = (r_op == OP_NEW_ACK) && !r_recovery &&
                      !(r_window < r_threshold) && (r_window != '0);
        mss_x2      = {r_mss, 1'b0};
        mss_x3      = {1'b0, mss_x2} + {2'b00, r_mss};
        half_win    = {1'b0, r_window[31:1]};
        new_thr     = (half_win < {15'd0, mss_x2}) ? {15'd0, mss_x2} : half_win;
        rto_x2      = {r_timeout, 1'b0};
        rto_next    = (rto_x2 > RTO_CAP) ? RTO_CAP[15:0] : rto_x2[15:0];
    end

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (in_accept) n_state = ST_EXEC;
            ST_EXEC:      n_state = use_div ? ST_MUL : ST_DONE;
            ST_MUL:       n_state = ST_DIV_START;
            ST_DIV_START: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (div_done) n_state = ST_DONE;
            ST_DONE:      if (!r_out_valid || i_m_tready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        s_ready   = 1'b0;
        exec_en   = 1'b0;
        mul_en    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE:      s_ready   = 1'b1;
            ST_EXEC:      exec_en   = !use_div;
            ST_MUL:       mul_en    = 1'b1;
            ST_DIV_START: div_start = 1'b1;
            ST_DIV_WAIT:  ;
            ST_DONE:      out_load  = !r_out_valid || i_m_tready;
            default:      ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    trcw_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_window),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mss          <= RESET_MSS;
            r_init_timeout <= RESET_TIMEOUT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MSS:     r_mss          <= i_cfg_data;
                CFG_TIMEOUT: r_init_timeout <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // event latch and mss squared
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op      <= i_s_tdata[1:0];
            r_unacked <= i_s_tdata[33:2];
        end
        if (mul_en) begin
            r_prod <= {16'd0, r_mss} * {16'd0, r_mss};
        end
    end

    // connection state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= {15'd0, RESET_MSS, 1'b0};
            r_threshold  <= START_THRESHOLD;
            r_dup_cnt    <= '0;
            r_recovery   <= 1'b0;
            r_timeout    <= RESET_TIMEOUT;
            r_rexmit     <= 1'b0;
            r_rexmit_len <= '0;
        end else if (div_done && r_state == ST_DIV_WAIT) begin
            r_window  <= sat_add(r_window, div_quo);
            r_dup_cnt <= '0;
            r_rexmit     <= 1'b0;
            r_rexmit_len <= '0;
        end else if (exec_en) begin
            r_rexmit     <= 1'b0;
            r_rexmit_len <= '0;
            unique case (r_op)
                OP_START: begin
                    r_window    <= {15'd0, mss_x2};
                    r_threshold <= START_THRESHOLD;
                    r_timeout   <= r_init_timeout;
                    r_dup_cnt   <= '0;
                    r_recovery  <= 1'b0;
                end
                OP_DUP_ACK: begin
                    r_dup_cnt <= dup_inc;
                    if (fast_rexmit) begin
                        r_threshold <= new_thr;
                        r_window    <= sat_add(new_thr, {14'd0, mss_x3});
                        r_recovery  <= 1'b1;
                        if (r_unacked != '0) begin
                            r_rexmit     <= 1'b1;
                            r_rexmit_len <= (r_unacked > {16'd0, r_mss}) ?
                                            r_mss : r_unacked[15:0];
                            r_timeout    <= rto_next;
                        end
                    end else if (r_recovery) begin
                        // window inflation during recovery
                        r_window <= sat_add(r_window, {16'd0, r_mss});
                    end
                end
                OP_NEW_ACK: begin
                    r_dup_cnt <= '0;
                    if (r_recovery) begin
                        r_window   <= r_threshold;
                        r_recovery <= 1'b0;
                    end else if (r_window < r_threshold) begin
                        r_window <= sat_add(r_window, {16'd0, r_mss});
                    end
                    // zero window: no growth
                end
                default: ;  // unused code: report state as is
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {r_timeout, r_rexmit_len, r_threshold, r_window};
            r_out_user <= {r_rexmit, r_recovery};
        end
    end

    assign o_s_tready  = s_ready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_user;

    // an accepted event blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_s_tready)
        else $error("input ready right after an accepted item");

    // recovery only follows the third duplicate
    a_recovery_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_recovery |-> (r_dup_cnt >= DUP_LIMIT))
        else $error("recovery with fewer than three duplicates");

    // a retransmit request always reports recovery
    a_rexmit_recovery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> o_m_tuser[0])
        else $error("retransmit request outside recovery");

    // the divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV_WAIT))
        else $error("divider done outside its wait state");

endmodule

// File: verif/reno_window_checker.sv
`timescale 1ns / 1ps

// Watches the event, result and register channels of the window engine,
// predicts every result and compares it field by field.
module reno_window_checker
    import trcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // [1:0] opcode, [33:2] bytes_in_flight
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [95:0] i_m_tdata,   // [31:0] cwnd, [63:32] ssthresh, [79:64] rexmit len,
                                     // [95:80] timeout
    input  logic [1:0]  i_m_tuser,   // [0] in_recovery, [1] retransmit_request
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_events,
    output int          o_results
);

    typedef struct packed {
        logic [31:0] cwnd;
        logic [31:0] ssthresh;
        logic        recovery;
        logic        rexmit;
        logic [15:0] rexmit_len;
        logic [15:0] rto;
    } t_window_result;

    // shadow registers and connection state
    logic [15:0] seg_size;
    logic [15:0] start_rto;
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    logic [3:0]  dup_count;
    logic        in_rec;
    logic [15:0] rto;

    t_window_result expected_results[$];

    function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Advances the connection state by one event and returns what it reports.
    function automatic t_window_result apply_event(input logic [1:0] op,
                                                   input logic [31:0] unacked);
        t_window_result r;
        logic [31:0]    seg;
        logic [31:0]    half;
        logic [16:0]    doubled;
        seg          = {16'd0, seg_size};
        r.rexmit     = 1'b0;
        r.rexmit_len = '0;
        case (op)
            OP_START: begin
                cwnd      = seg << 1;
                ssthresh  = START_THRESHOLD;
                rto       = start_rto;
                dup_count = '0;
                in_rec    = 1'b0;
            end
            OP_DUP_ACK: begin
                if (dup_count != DUP_SAT)
                    dup_count = dup_count + 4'd1;
                if (dup_count == DUP_LIMIT && !in_rec) begin
                    half     = cwnd >> 1;
                    ssthresh = (half < (seg << 1)) ? (seg << 1) : half;
                    cwnd     = add_clamped(ssthresh, seg * 32'd3);
                    in_rec   = 1'b1;
                    if (unacked != 32'd0) begin
                        doubled      = {rto, 1'b0};
                        r.rexmit     = 1'b1;
                        r.rexmit_len = (unacked > seg) ? seg[15:0] : unacked[15:0];
                        rto          = (doubled > RTO_CAP) ? RTO_CAP[15:0] : doubled[15:0];
                    end
                end else if (in_rec) begin
                    cwnd = add_clamped(cwnd, seg);
                end
            end
            OP_NEW_ACK: begin
                dup_count = '0;
                if (in_rec) begin
                    cwnd   = ssthresh;
                    in_rec = 1'b0;
                end else if (cwnd < ssthresh) begin
                    cwnd = add_clamped(cwnd, seg);
                end else if (cwnd != 32'd0) begin
                    cwnd = add_clamped(cwnd, (seg * seg) / cwnd);
                end
            end
            default: ;  // unused code: state untouched
        endcase
        r.cwnd     = cwnd;
        r.ssthresh = ssthresh;
        r.recovery = in_rec;
        r.rto      = rto;
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got === want)
            return 0;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin : track
        t_window_result want;
        t_window_result seen;
        int             nfail;
        if (!i_rst_n) begin
            seg_size  = RESET_MSS;
            start_rto = RESET_TIMEOUT;
            cwnd      = {15'd0, RESET_MSS, 1'b0};
            ssthresh  = START_THRESHOLD;
            dup_count = '0;
            in_rec    = 1'b0;
            rto       = RESET_TIMEOUT;
            expected_results.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
            o_events     <= 0;
            o_results    <= 0;
        end else begin
            nfail = o_fail_count;
            if (i_m_tvalid && i_m_tready) begin
                seen.cwnd       = i_m_tdata[31:0];
                seen.ssthresh   = i_m_tdata[63:32];
                seen.rexmit_len = i_m_tdata[79:64];
                seen.rto        = i_m_tdata[95:80];
                seen.recovery   = i_m_tuser[0];
                seen.rexmit     = i_m_tuser[1];
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, expected nothing, actual 0x%0h",
                             $time, seen);
                    nfail++;
                end else begin
                    want  = expected_results.pop_front();
                    nfail += field_differs("congestion_window", want.cwnd, seen.cwnd);
                    nfail += field_differs("slow_start_threshold", want.ssthresh,
                                           seen.ssthresh);
                    nfail += field_differs("in_recovery", {31'd0, want.recovery},
                                           {31'd0, seen.recovery});
                    nfail += field_differs("retransmit_request", {31'd0, want.rexmit},
                                           {31'd0, seen.rexmit});
                    nfail += field_differs("retransmit_length", {16'd0, want.rexmit_len},
                                           {16'd0, seen.rexmit_len});
                    nfail += field_differs("timeout_value", {16'd0, want.rto},
                                           {16'd0, seen.rto});
                end
                o_results <= o_results + 1;
            end
            // a write lands before any event taken at the same edge
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_MSS)
                    seg_size = i_cfg_data;
                else
                    start_rto = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(apply_event(i_s_tdata[1:0], i_s_tdata[33:2]));
                o_events <= o_events + 1;
            end
            o_fail_count <= nfail;
            o_pending    <= expected_results.size();
        end
    end

endmodule

// File: verif/tcp_reno_congestion_window_tb.sv
`timescale 1ns / 1ps

// Top of the window engine bench: drives events, register writes and the
// result sink, and gives the verdict. All checking sits in the checker.
module tcp_reno_congestion_window_tb;
    import trcw_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;     // no event code, must be a no-op
    localparam int         STALL_LIMIT   = 3000;     // cycles with no handshake at all
    localparam int         LONG_HOLD     = 400;      // sink hold that backs up the input
    localparam int         HOLD_AFTER    = 60;       // results seen before the hold
    localparam int         RANDOM_PHASES = 8;
    localparam int         PHASE_ITEMS   = 100;
    localparam int         INFLATE_DUPS  = 40;       // mss=65535 inflations in recovery
    localparam int         DRAIN_CYCLES  = 60;       // wait after the last drain

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [39:0] i_s_tdata   = '0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = CFG_MSS;
    logic [15:0] i_cfg_data  = '0;

    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [95:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_cfg_ready;

    int fail_count;
    int pending;
    int events_seen;
    int results_seen;

    // 1-in-N chance of an idle burst on each side; 0 turns idling off
    int          idle_odds      = 0;
    bit          long_hold_done = 1'b0;
    int          cfg_writes     = 0;
    int          settings_run   = 1;   // reset values count as the first setting
    logic [15:0] cur_mss        = RESET_MSS;
    int          quiet_cycles   = 0;

    tcp_reno_congestion_window u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    reno_window_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_events     (events_seen),
        .o_results    (results_seen)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: any handshake on any channel counts as progress. The worst
    // legal quiet stretch is the long sink hold plus one divide and a gap.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, pending);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Result sink. Random not-ready bursts, plus one long hold once traffic
    // is flowing: the block parks one result, takes one more event, then
    // has to stall its input while the sender keeps offering.
    initial begin : sink
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_done = 1'b1;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    // One event item. Valid stays up into the next call unless a gap is
    // drawn here or the caller drops it, so back-to-back items never see a
    // low/high pair in one step.
    task automatic send_event(input logic [1:0] op, input logic [31:0] unacked);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, unacked, op};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait for every predicted result to come back.
    // The first edge lets the checker count the last event taken.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Both registers in one burst; only called with the block idle.
    task automatic load_setting(input logic [15:0] mss, input logic [15:0] rto);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MSS;
        i_cfg_data  <= mss;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= CFG_TIMEOUT;
        i_cfg_data  <= rto;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_mss      = mss;
        cfg_writes  += 2;
        settings_run++;
    endtask

    // Outstanding byte counts: none, everything, around one segment, random.
    function automatic logic [31:0] pick_unacked();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(1, cur_mss + 1);
            3:       return $urandom & 32'h0000_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Start, fast retransmit with data out, one inflation, recovery exit,
    // then one avoidance step. Exercises the timeout and zero-mss corners.
    task automatic retransmit_probe();
        send_event(OP_START, 32'd0);
        send_event(OP_DUP_ACK, 32'd5);
        send_event(OP_DUP_ACK, 32'd5);
        send_event(OP_DUP_ACK, 32'hFFFF_FFFF);
        send_event(OP_DUP_ACK, 32'd5);
        send_event(OP_NEW_ACK, 32'd0);
        send_event(OP_NEW_ACK, 32'd0);
    endtask

    // Mostly ACK clocking: runs of new ACKs, duplicate runs that do or do
    // not reach the third duplicate, restarts, and some noise.
    task automatic random_traffic(input int count);
        int         sent;
        int         run;
        logic [1:0] op;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 19))
                0: begin
                    send_event(OP_START, pick_unacked());
                    sent++;
                end
                1: begin
                    op = 2'($urandom_range(0, 3));
                    send_event(op, $urandom);
                    sent++;
                end
                2, 3, 4, 5: begin
                    // long runs walk the duplicate count into saturation
                    run = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20)
                                                      : $urandom_range(1, 5);
                    repeat (run) send_event(OP_DUP_ACK, pick_unacked());
                    sent += run;
                end
                default: begin
                    run = $urandom_range(1, 8);
                    repeat (run) send_event(OP_NEW_ACK, pick_unacked());
                    sent += run;
                end
            endcase
        end
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass on reset values, no idling.
        send_event(OP_NEW_ACK, 32'd0);             // slow start straight out of reset
        send_event(OP_NEW_ACK, 32'hFFFF_FFFF);
        send_event(OP_UNUSED, 32'h0001_2345);      // unused code reports state only
        send_event(OP_START, 32'd0);
        send_event(OP_DUP_ACK, 32'd0);
        send_event(OP_DUP_ACK, 32'd0);
        send_event(OP_DUP_ACK, 32'hFFFF_FFFF);     // fires, length clipped to mss
        send_event(OP_DUP_ACK, 32'd7);             // inflation in recovery
        send_event(OP_NEW_ACK, 32'd0);             // leaves recovery at ssthresh
        send_event(OP_NEW_ACK, 32'd1000);          // congestion avoidance divide
        send_event(OP_NEW_ACK, 32'd1000);
        send_event(OP_DUP_ACK, 32'd0);
        send_event(OP_DUP_ACK, 32'd0);
        send_event(OP_DUP_ACK, 32'd0);             // third dup, nothing outstanding
        send_event(OP_DUP_ACK, 32'd0);
        send_event(OP_NEW_ACK, 32'd0);
        send_event(OP_START, 32'd0);
        send_event(OP_DUP_ACK, 32'd100);
        send_event(OP_DUP_ACK, 32'd100);
        send_event(OP_DUP_ACK, 32'd100);           // length is the short unacked count
        send_event(OP_UNUSED, 32'hFFFF_FFFF);      // no-op inside recovery
        send_event(OP_START, 32'd0);               // start clears recovery
        send_event(OP_NEW_ACK, 32'd0);
        drain_results();

        // Register extremes, including values outside the nominal ranges:
        // zero mss (zero window in avoidance), zero timeout, timeout above cap.
        load_setting(16'd1, 16'd1);
        retransmit_probe();
        drain_results();
        load_setting(16'hFFFF, 16'd64000);
        retransmit_probe();
        drain_results();
        load_setting(16'd0, 16'd0);
        retransmit_probe();
        drain_results();
        load_setting(16'd536, 16'hFFFF);
        retransmit_probe();
        drain_results();

        // Random phases; each picks its own idling density, some with none.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 3))
                0:       load_setting(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 64000)));
                1:       load_setting(16'($urandom_range(1, 1500)), 16'($urandom_range(1, 64000)));
                2:       load_setting(16'($urandom_range(1, 64)), 16'($urandom_range(30000, 64000)));
                default: load_setting(RESET_MSS, RESET_TIMEOUT);
            endcase
            idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 8);
            send_event(OP_START, 32'd0);
            random_traffic(PHASE_ITEMS);
            drain_results();
        end

        // Last part, no idling anywhere: inflate the window with a long run
        // of max-size segments back to back, then leave recovery.
        idle_odds = 0;
        load_setting(16'hFFFF, 16'd64000);
        send_event(OP_START, 32'd0);
        repeat (3 + INFLATE_DUPS) send_event(OP_DUP_ACK, 32'hFFFF_FFFF);
        send_event(OP_NEW_ACK, 32'd0);
        send_event(OP_NEW_ACK, 32'd0);
        drain_results();

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d events and checked %0d results over %0d register settings (%0d writes)",
                 events_seen, results_seen, settings_run, cfg_writes);
        $display("including a %0d-cycle sink hold and a window inflated by %0d duplicate ACKs",
                 LONG_HOLD, INFLATE_DUPS);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/trcw_pkg.sv
design/trcw_divider.sv
design/tcp_reno_congestion_window.sv
verif/reno_window_checker.sv
verif/tcp_reno_congestion_window_tb.sv
